@@ hw/rtl/sdspi_pkg.sv @@
// Package for the SD card SPI-mode command engine.
// Holds the item structs, phase/operation/status codes and the CRC7 byte step.
// No dependencies.
package sdspi_pkg;

  localparam int unsigned BLOCK_BYTES = 512;
  localparam int unsigned CNT_W       = $clog2(BLOCK_BYTES + 1);
  localparam int unsigned TIMEOUT_W   = 17;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 17'h10000;
  localparam logic [7:0]           IDLE_BYTE     = 8'hFF;
  localparam logic [7:0]           DATA_TOKEN    = 8'hFE;
  localparam logic [6:0]           CRC7_POLY     = 7'h09;
  localparam logic [1:0]           CMD_PREFIX    = 2'b01;

  typedef enum logic [0:0] {
    REQ_START = 1'b0,
    REQ_RX    = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    OP_R1   = 2'd0,
    OP_R7   = 2'd1,
    OP_READ = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TIMEOUT  = 2'd1,
    ST_R7_REJ   = 2'd2,
    ST_NO_TOKEN = 2'd3
  } status_e;

  typedef enum logic [6:0] {
    PH_IDLE  = 7'b0000001,
    PH_SEND  = 7'b0000010,
    PH_R1    = 7'b0000100,
    PH_R7    = 7'b0001000,
    PH_TOKEN = 7'b0010000,
    PH_DATA  = 7'b0100000,
    PH_CRC   = 7'b1000000
  } phase_e;

  typedef struct packed {
    logic        req_type;
    logic [5:0]  cmd_index;
    logic [31:0] argument;
    logic [1:0]  op_kind;
    logic [7:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        data_valid;
    logic [7:0]  data_byte;
    logic        done_res;
    logic [1:0]  status;
    logic [7:0]  response;
    logic [31:0] payload;
    logic [15:0] block_crc;
  } out_item_t;

  // Advances the CRC7 (x^7 + x^3 + 1) by one byte, most significant bit first.
  function automatic logic [6:0] crc7_byte(input logic [6:0] crc_in, input logic [7:0] data);
    logic [6:0] c;
    logic       fb;
    c = crc_in;
    for (int b = 7; b >= 0; b--) begin
      fb = data[b] ^ c[6];
      c  = {c[5:0], 1'b0};
      if (fb) begin
        c = c ^ CRC7_POLY;
      end
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/sd_spi_command_engine.sv @@
// Top level of the SD card SPI-mode command engine.
// Depends on sdspi_pkg for the item structs, codes and the CRC7 byte step.
//
// A start item latches a command and yields the first byte to send; each
// received-byte item then yields one result with the next byte to send, a
// block data byte, or the final status. Every item is handled by the
// combinational state update and lands in a single output register, so the
// block takes one item per cycle as long as results are taken; only a
// received byte while idle gives no result. The command CRC7 is built one
// byte per item as the frame goes out.
module sd_spi_command_engine (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  sdspi_pkg::in_item_t                  in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output sdspi_pkg::out_item_t                 out_data_o,
  input  logic                                 cfg_we_i,
  input  logic [sdspi_pkg::TIMEOUT_W-1:0]      cfg_wdata_i
);
  import sdspi_pkg::*;

  logic [TIMEOUT_W-1:0] timeout_q;
  phase_e               phase_q, phase_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [TIMEOUT_W-1:0] poll_q, poll_d;
  logic [39:0]          frame_q, frame_d;
  logic [6:0]           crc_q, crc_d;
  op_e                  op_q, op_d;
  logic [7:0]           r1_q, r1_d;
  logic [31:0]          pay_q, pay_d;
  logic [15:0]          bcrc_q, bcrc_d;

  logic                 out_valid_q;
  out_item_t            out_q;
  out_item_t            res;
  logic                 has_res;
  logic                 accept;
  logic [TIMEOUT_W:0]   poll_next;
  logic                 poll_expired;
  logic [7:0]           rx;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign rx           = in_data_i.rx_byte;
  assign poll_next    = {1'b0, poll_q} + {{TIMEOUT_W{1'b0}}, 1'b1};
  assign poll_expired = poll_next > {1'b0, timeout_q};

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    poll_d  = poll_q;
    frame_d = frame_q;
    crc_d   = crc_q;
    op_d    = op_q;
    r1_d    = r1_q;
    pay_d   = pay_q;
    bcrc_d  = bcrc_q;
    has_res = 1'b1;
    res          = '0;
    res.tx_valid = 1'b1;
    res.tx_byte  = IDLE_BYTE;

    if (in_data_i.req_type == REQ_START) begin
      frame_d = {CMD_PREFIX, in_data_i.cmd_index, in_data_i.argument};
      crc_d   = crc7_byte(7'd0, {CMD_PREFIX, in_data_i.cmd_index});
      case (in_data_i.op_kind)
        OP_R7:   op_d = OP_R7;
        OP_READ: op_d = OP_READ;
        default: op_d = OP_R1;
      endcase
      phase_d = PH_SEND;
      cnt_d   = CNT_W'(1);
      poll_d  = '0;
      pay_d   = '0;
      bcrc_d  = '0;
      r1_d    = IDLE_BYTE;
    end else begin
      case (phase_q)
        PH_SEND: begin
          if (cnt_q < CNT_W'(8)) begin
            cnt_d = cnt_q + CNT_W'(1);
          end
          case (cnt_q)
            CNT_W'(0): res.tx_byte = 8'h00;
            CNT_W'(1): res.tx_byte = frame_q[39:32];
            CNT_W'(2): res.tx_byte = frame_q[31:24];
            CNT_W'(3): res.tx_byte = frame_q[23:16];
            CNT_W'(4): res.tx_byte = frame_q[15:8];
            CNT_W'(5): res.tx_byte = frame_q[7:0];
            CNT_W'(6): res.tx_byte = {crc_q, 1'b1};
            CNT_W'(7): res.tx_byte = IDLE_BYTE;
            default: begin
              phase_d = PH_R1;
              poll_d  = '0;
            end
          endcase
          if (cnt_q inside {CNT_W'(2), CNT_W'(3), CNT_W'(4), CNT_W'(5)}) begin
            crc_d = crc7_byte(crc_q, res.tx_byte);
          end
        end
        PH_R1: begin
          if (rx == IDLE_BYTE) begin
            if (poll_expired) begin
              phase_d      = PH_IDLE;
              res.tx_valid = 1'b0;
              res.tx_byte  = '0;
              res.done_res = 1'b1;
              res.status   = ST_TIMEOUT;
              res.response = IDLE_BYTE;
            end else begin
              poll_d = poll_next[TIMEOUT_W-1:0];
            end
          end else begin
            r1_d = rx;
            case (op_q)
              OP_R7: begin
                if (rx > 8'd1) begin
                  phase_d      = PH_IDLE;
                  res.tx_valid = 1'b0;
                  res.tx_byte  = '0;
                  res.done_res = 1'b1;
                  res.status   = ST_R7_REJ;
                  res.response = IDLE_BYTE;
                end else begin
                  phase_d = PH_R7;
                  cnt_d   = '0;
                  pay_d   = '0;
                end
              end
              OP_READ: begin
                phase_d = PH_TOKEN;
                poll_d  = '0;
              end
              default: begin
                phase_d      = PH_IDLE;
                res.tx_valid = 1'b0;
                res.tx_byte  = '0;
                res.done_res = 1'b1;
                res.status   = ST_OK;
                res.response = rx;
              end
            endcase
          end
        end
        PH_R7: begin
          pay_d = {pay_q[23:0], rx};
          cnt_d = cnt_q + CNT_W'(1);
          if (cnt_q >= CNT_W'(3)) begin
            phase_d      = PH_IDLE;
            res.tx_valid = 1'b0;
            res.tx_byte  = '0;
            res.done_res = 1'b1;
            res.status   = ST_OK;
            res.response = r1_q;
            res.payload  = {pay_q[23:0], rx};
          end
        end
        PH_TOKEN: begin
          if (rx == IDLE_BYTE) begin
            if (poll_expired) begin
              phase_d      = PH_IDLE;
              res.tx_valid = 1'b0;
              res.tx_byte  = '0;
              res.done_res = 1'b1;
              res.status   = ST_NO_TOKEN;
              res.response = IDLE_BYTE;
            end else begin
              poll_d = poll_next[TIMEOUT_W-1:0];
            end
          end else if (rx == DATA_TOKEN) begin
            phase_d = PH_DATA;
            cnt_d   = '0;
          end else begin
            phase_d      = PH_IDLE;
            res.tx_valid = 1'b0;
            res.tx_byte  = '0;
            res.done_res = 1'b1;
            res.status   = ST_NO_TOKEN;
            res.response = rx;
          end
        end
        PH_DATA: begin
          res.data_valid = 1'b1;
          res.data_byte  = rx;
          if (cnt_q >= CNT_W'(BLOCK_BYTES - 1)) begin
            phase_d = PH_CRC;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
        PH_CRC: begin
          bcrc_d = {bcrc_q[7:0], rx};
          cnt_d  = cnt_q + CNT_W'(1);
          if (cnt_q >= CNT_W'(1)) begin
            phase_d       = PH_IDLE;
            res.tx_valid  = 1'b0;
            res.tx_byte   = '0;
            res.done_res  = 1'b1;
            res.status    = ST_OK;
            res.response  = DATA_TOKEN;
            res.block_crc = {bcrc_q[7:0], rx};
          end
        end
        default: begin
          has_res = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      poll_q  <= '0;
      frame_q <= '0;
      crc_q   <= '0;
      op_q    <= OP_R1;
      r1_q    <= IDLE_BYTE;
      pay_q   <= '0;
      bcrc_q  <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      poll_q  <= poll_d;
      frame_q <= frame_d;
      crc_q   <= crc_d;
      op_q    <= op_d;
      r1_q    <= r1_d;
      pay_q   <= pay_d;
      bcrc_q  <= bcrc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && has_res) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && has_res) begin
      out_q <= res;
    end
  end

  // A result that ends the command leaves the engine idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && has_res && res.done_res) |=> (phase_q == PH_IDLE))
    else $error("command finished but engine not idle");

  // A start item always begins the frame with the dummy byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.req_type == REQ_START) |=>
      (phase_q == PH_SEND && cnt_q == CNT_W'(1) && out_valid_q
       && out_q.tx_valid && out_q.tx_byte == IDLE_BYTE))
    else $error("start item did not begin a frame");

  // Data bytes are only delivered while the engine keeps clocking the bus.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.data_valid) |-> (out_q.tx_valid && !out_q.done_res))
    else $error("data byte on a finishing or idle result");

  // Frame sending never runs past the trailing byte count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_SEND) |-> (cnt_q <= CNT_W'(8)))
    else $error("frame byte count out of range");

endmodule
